@@ rtl/lsrc_pkg.sv @@
package lsrc_pkg;

	// coordinate width
	localparam int CB = 16;

	// differences, numerators and denominators
	localparam int NW = CB + 1;
	// cross products
	localparam int PW = 2 * CB + 2;
	// interpolation numerators (sum of two products)
	localparam int SW = 2 * CB + 3;
	// numerator magnitude
	localparam int MW = SW - 1;
	// quotient magnitude bits; larger results saturate anyway
	localparam int QB = CB;

	localparam int IN_W  = ((4 * CB + 7) / 8) * 8;
	localparam int OUT_W = ((4 * CB + 1 + 7) / 8) * 8;

	localparam int REG_IDX_W = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MIN_X = 2'd0,
		REG_MIN_Y = 2'd1,
		REG_MAX_X = 2'd2,
		REG_MAX_Y = 2'd3
	} reg_idx_t;

	localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};

	// per-item side data carried down the pipe
	typedef struct packed {
		logic signed [CB-1:0] sx;   // start x (clamped result for horizontal segments)
		logic signed [CB-1:0] sy;
		logic signed [CB-1:0] ex;
		logic signed [CB-1:0] ey;
		logic                 ax_vis;
		logic                 gen;  // neither dx nor dy is zero
		logic                 mv_s; // start point moves
		logic                 mv_e; // end point moves
		logic                 vis_g;
	} side_t;

	// one divider lane
	typedef struct packed {
		logic [MW-1:0] rem;
		logic [QB-1:0] quo;
		logic [CB-1:0] den;
		logic          neg;
		logic          ovf;
	} lane_t;

endpackage

@@ rtl/line_segment_rect_clip_core.sv @@
// Channel   | Dir | Handshake              | Payload (lowest bits first)
// ----------+-----+------------------------+------------------------------------------
// s_axis    | in  | s_axis_tvalid/tready   | start_x, start_y, end_x, end_y
// m_axis    | out | m_axis_tvalid/tready   | clipped_start_x/y, clipped_end_x/y, visible
// cfg       | in  | cfg_we (no wait)       | cfg_addr = register index, cfg_wdata
//
// One segment per cycle sustained while m_axis_tready stays high. The pipe is
// five arithmetic stages, one divider setup stage, one restoring divider step
// per quotient bit, and the output register. The divider chain sets the
// depth; the multiplier stages set the per-stage logic.
// arst_n clears all valid bits and loads the clip registers with their reset
// values. Each stage holds when its successor is full and stalled, so bubbles
// close up under backpressure and no transfer is lost or repeated.
module line_segment_rect_clip_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lsrc_pkg::REG_IDX_W-1:0]  cfg_addr,
	input  logic [lsrc_pkg::CB-1:0]         cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// start_x, start_y, end_x, end_y
	input  logic [lsrc_pkg::IN_W-1:0]       s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y, visible
	output logic [lsrc_pkg::OUT_W-1:0]      m_axis_tdata
);
	import lsrc_pkg::*;

	localparam logic signed [CB:0] QMAX = {2'b00, {(CB-1){1'b1}}};
	localparam logic signed [CB:0] QMIN = {2'b11, {(CB-1){1'b0}}};

	function automatic logic signed [CB-1:0] clampc(input logic signed [CB-1:0] v,
		input logic signed [CB-1:0] lo, input logic signed [CB-1:0] hi);
		logic signed [CB-1:0] r;
		r = (v < hi) ? v : hi;
		return (r > lo) ? r : lo;
	endfunction

	// clip rectangle
	logic signed [CB-1:0] min_x_q, min_y_q, max_x_q, max_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0;
			min_y_q <= '0;
			max_x_q <= COORD_MAX;
			max_y_q <= COORD_MAX;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_MIN_X: min_x_q <= cfg_wdata;
				REG_MIN_Y: min_y_q <= cfg_wdata;
				REG_MAX_X: max_x_q <= cfg_wdata;
				REG_MAX_Y: max_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when its successor loads
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_o;
	logic en_d [0:QB+1];
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_vld_q;
	logic div_vld_s [0:QB];

	assign en_o          = !out_vld_q || m_axis_tready;
	assign en_d[QB+1]    = en_o;
	assign en_d[QB]      = !div_vld_s[QB] || en_d[QB+1];
	assign en_s5         = !v_s5 || en_d[0];
	assign en_s4         = !v_s4 || en_s5;
	assign en_s3         = !v_s3 || en_s4;
	assign en_s2         = !v_s2 || en_s3;
	assign en_s1         = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	// ---------------- stage 1: deltas, edge numerators, axis cases ----------------
	logic signed [CB-1:0] in_x1, in_y1, in_x2, in_y2;
	logic signed [NW-1:0] c_dx, c_dy, c_ex, c_fx, c_ey, c_fy, c_xd, c_yd;
	logic signed [CB-1:0] c_cy1, c_cy2, c_cx1, c_cx2;
	side_t                c_side;

	assign in_x1 = s_axis_tdata[0 +: CB];
	assign in_y1 = s_axis_tdata[CB +: CB];
	assign in_x2 = s_axis_tdata[2*CB +: CB];
	assign in_y2 = s_axis_tdata[3*CB +: CB];

	always_comb begin
		c_dx  = NW'(in_x2) - NW'(in_x1);
		c_dy  = NW'(in_y2) - NW'(in_y1);
		c_cy1 = clampc(in_y1, min_y_q, max_y_q);
		c_cy2 = clampc(in_y2, min_y_q, max_y_q);
		c_cx1 = clampc(in_x1, min_x_q, max_x_q);
		c_cx2 = clampc(in_x2, min_x_q, max_x_q);

		if (c_dx > 0) begin
			c_ex = NW'(min_x_q) - NW'(in_x1);
			c_fx = NW'(max_x_q) - NW'(in_x1);
			c_xd = c_dx;
		end else begin
			c_ex = NW'(in_x1) - NW'(max_x_q);
			c_fx = NW'(in_x1) - NW'(min_x_q);
			c_xd = -c_dx;
		end
		if (c_dy > 0) begin
			c_ey = NW'(min_y_q) - NW'(in_y1);
			c_fy = NW'(max_y_q) - NW'(in_y1);
			c_yd = c_dy;
		end else begin
			c_ey = NW'(in_y1) - NW'(max_y_q);
			c_fy = NW'(in_y1) - NW'(min_y_q);
			c_yd = -c_dy;
		end

		c_side       = '0;
		c_side.sx    = in_x1;
		c_side.sy    = in_y1;
		c_side.ex    = in_x2;
		c_side.ey    = in_y2;
		c_side.gen   = (c_dx != 0) && (c_dy != 0);
		if (c_dx == 0) begin
			// vertical segment or single point
			c_side.sy     = c_cy1;
			c_side.ey     = c_cy2;
			c_side.ax_vis = (in_x1 >= min_x_q) && (in_x1 <= max_x_q) &&
				(((in_y1 < in_y2) ? in_y1 : in_y2) <= max_y_q) &&
				(((in_y1 > in_y2) ? in_y1 : in_y2) >= min_y_q) &&
				(c_cy1 != c_cy2);
		end else if (c_dy == 0) begin
			c_side.sx     = c_cx1;
			c_side.ex     = c_cx2;
			c_side.ax_vis = (in_y1 >= min_y_q) && (in_y1 <= max_y_q) &&
				(((in_x1 < in_x2) ? in_x1 : in_x2) <= max_x_q) &&
				(((in_x1 > in_x2) ? in_x1 : in_x2) >= min_x_q) &&
				(c_cx1 != c_cx2);
		end
	end

	side_t                side_s1;
	logic signed [NW-1:0] dx_s1, dy_s1, ex_s1, fx_s1, ey_s1, fy_s1, xd_s1, yd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en_s1) v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			side_s1 <= c_side;
			dx_s1   <= c_dx;
			dy_s1   <= c_dy;
			ex_s1   <= c_ex;
			fx_s1   <= c_fx;
			ey_s1   <= c_ey;
			fy_s1   <= c_fy;
			xd_s1   <= c_xd;
			yd_s1   <= c_yd;
		end
	end

	// ---------------- stage 2: cross products for entry/exit choice ----------------
	side_t                side_s2;
	logic signed [NW-1:0] dx_s2, dy_s2, ex_s2, fx_s2, ey_s2, fy_s2, xd_s2, yd_s2;
	logic signed [PW-1:0] p_eyxd_s2, p_exyd_s2, p_fyxd_s2, p_fxyd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en_s2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			side_s2   <= side_s1;
			dx_s2     <= dx_s1;
			dy_s2     <= dy_s1;
			ex_s2     <= ex_s1;
			fx_s2     <= fx_s1;
			ey_s2     <= ey_s1;
			fy_s2     <= fy_s1;
			xd_s2     <= xd_s1;
			yd_s2     <= yd_s1;
			p_eyxd_s2 <= PW'(ey_s1) * PW'(xd_s1);
			p_exyd_s2 <= PW'(ex_s1) * PW'(yd_s1);
			p_fyxd_s2 <= PW'(fy_s1) * PW'(xd_s1);
			p_fxyd_s2 <= PW'(fx_s1) * PW'(yd_s1);
		end
	end

	// ---------------- stage 3: pick entry and exit parameters ----------------
	side_t                side_s3;
	logic signed [NW-1:0] dx_s3, dy_s3, nn_s3, nd_s3, fn_s3, fd_s3;
	logic                 near_y, far_y;

	assign near_y = p_eyxd_s2 > p_exyd_s2;
	assign far_y  = p_fyxd_s2 < p_fxyd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en_s3) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			side_s3 <= side_s2;
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			nn_s3   <= near_y ? ey_s2 : ex_s2;
			nd_s3   <= near_y ? yd_s2 : xd_s2;
			fn_s3   <= far_y ? fy_s2 : fx_s2;
			fd_s3   <= far_y ? yd_s2 : xd_s2;
		end
	end

	// ---------------- stage 4: interpolation and visibility products ----------------
	side_t                side_s4;
	side_t                c_side4;
	logic signed [NW-1:0] nd_s4, fd_s4;
	logic signed [PW-1:0] pv1_s4, pv2_s4;
	logic signed [PW-1:0] pa_s4 [0:3];
	logic signed [PW-1:0] pb_s4 [0:3];
	logic                 vpart_s4;

	always_comb begin
		c_side4      = side_s3;
		c_side4.mv_s = (nn_s3 >= 0) && (nn_s3 != nd_s3);
		c_side4.mv_e = fn_s3 < fd_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en_s4) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			side_s4   <= c_side4;
			nd_s4     <= nd_s3;
			fd_s4     <= fd_s3;
			vpart_s4  <= (nn_s3 < nd_s3) && (fn_s3 > 0);
			pv1_s4    <= PW'(nn_s3) * PW'(fd_s3);
			pv2_s4    <= PW'(fn_s3) * PW'(nd_s3);
			pa_s4[0]  <= PW'(side_s3.sx) * PW'(nd_s3);
			pb_s4[0]  <= PW'(nn_s3) * PW'(dx_s3);
			pa_s4[1]  <= PW'(side_s3.sy) * PW'(nd_s3);
			pb_s4[1]  <= PW'(nn_s3) * PW'(dy_s3);
			pa_s4[2]  <= PW'(side_s3.sx) * PW'(fd_s3);
			pb_s4[2]  <= PW'(fn_s3) * PW'(dx_s3);
			pa_s4[3]  <= PW'(side_s3.sy) * PW'(fd_s3);
			pb_s4[3]  <= PW'(fn_s3) * PW'(dy_s3);
		end
	end

	// ---------------- stage 5: numerator sums, visibility compare ----------------
	side_t                side_s5;
	side_t                c_side5;
	logic signed [NW-1:0] nd_s5, fd_s5;
	logic signed [SW-1:0] num_s5 [0:3];

	always_comb begin
		c_side5       = side_s4;
		c_side5.vis_g = vpart_s4 && (pv1_s4 < pv2_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en_s5) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			side_s5 <= c_side5;
			nd_s5   <= nd_s4;
			fd_s5   <= fd_s4;
			for (int l = 0; l < 4; l++) begin
				num_s5[l] <= SW'(pa_s4[l]) + SW'(pb_s4[l]);
			end
		end
	end

	// ---------------- divider: setup, then one quotient bit per stage ----------------
	side_t div_side_s [0:QB];
	lane_t div_lane_s [0:QB][0:3];
	lane_t c_setup [0:3];

	always_comb begin
		logic signed [SW-1:0] nabs;
		nabs = '0;
		for (int l = 0; l < 4; l++) begin
			c_setup[l].neg = num_s5[l] < 0;
			nabs           = c_setup[l].neg ? -num_s5[l] : num_s5[l];
			c_setup[l].rem = nabs[MW-1:0];
			c_setup[l].den = (l < 2) ? nd_s5[CB-1:0] : fd_s5[CB-1:0];
			c_setup[l].quo = '0;
			// quotient would not fit in QB bits: saturates at the output
			c_setup[l].ovf = c_setup[l].rem >= (MW'(c_setup[l].den) << QB);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_vld_s[0] <= 1'b0;
		else if (en_d[0]) div_vld_s[0] <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en_d[0]) begin
			div_side_s[0] <= side_s5;
			for (int l = 0; l < 4; l++) div_lane_s[0][l] <= c_setup[l];
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int B = QB - 1 - k;
		lane_t nxt [0:3];

		assign en_d[k] = !div_vld_s[k] || en_d[k+1];

		always_comb begin
			logic [MW-1:0] sh;
			sh = '0;
			for (int l = 0; l < 4; l++) begin
				nxt[l] = div_lane_s[k][l];
				sh     = MW'(div_lane_s[k][l].den) << B;
				if (div_lane_s[k][l].rem >= sh) begin
					nxt[l].rem    = div_lane_s[k][l].rem - sh;
					nxt[l].quo[B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_vld_s[k+1] <= 1'b0;
			else if (en_d[k+1]) div_vld_s[k+1] <= div_vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en_d[k+1]) begin
				div_side_s[k+1] <= div_side_s[k];
				for (int l = 0; l < 4; l++) div_lane_s[k+1][l] <= nxt[l];
			end
		end
	end

	// ---------------- output: sign, saturate, select ----------------
	logic signed [CB-1:0] qv [0:3];
	logic [OUT_W-1:0]     c_out;
	logic [OUT_W-1:0]     out_data_q;
	side_t                fs;

	assign fs = div_side_s[QB];

	always_comb begin
		logic signed [CB:0] sv;
		sv = '0;
		for (int l = 0; l < 4; l++) begin
			sv = div_lane_s[QB][l].neg ? -$signed({1'b0, div_lane_s[QB][l].quo})
				: $signed({1'b0, div_lane_s[QB][l].quo});
			if (div_lane_s[QB][l].ovf) qv[l] = div_lane_s[QB][l].neg ? COORD_MIN : COORD_MAX;
			else if (sv > QMAX) qv[l] = COORD_MAX;
			else if (sv < QMIN) qv[l] = COORD_MIN;
			else qv[l] = sv[CB-1:0];
		end
		c_out            = '0;
		c_out[0 +: CB]    = (fs.gen && fs.mv_s) ? qv[0] : fs.sx;
		c_out[CB +: CB]   = (fs.gen && fs.mv_s) ? qv[1] : fs.sy;
		c_out[2*CB +: CB] = (fs.gen && fs.mv_e) ? qv[2] : fs.ex;
		c_out[3*CB +: CB] = (fs.gen && fs.mv_e) ? qv[3] : fs.ey;
		c_out[4*CB]       = fs.gen ? fs.vis_g : fs.ax_vis;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en_o) out_vld_q <= div_vld_s[QB];
	end

	always_ff @(posedge clk) begin
		if (en_o) out_data_q <= c_out;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// ---------------- assertions ----------------
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output register");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted transfer not in stage 1");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en_s2 |=> v_s1 && $stable(side_s1))
		else $error("stage 1 item lost during stall");

	a_out_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		en_o && div_vld_s[QB] |=> m_axis_tvalid)
		else $error("divider result not moved to output");

endmodule
